@@ rtl/grld_pkg.sv @@
// Shared types and constants of the glyph run-length decoder.
// Depends on nothing; every other file of the block imports it.
package grld_pkg;

    localparam int unsigned GROUP = 4;
    localparam logic [7:0] ESCAPE_BYTE = 8'h41;
    localparam logic [7:0] RUN_BIAS = 8'h40;

    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA = 1'b1;

    localparam logic CFG_FORMAT = 1'b0;
    localparam logic CFG_PITCH = 1'b1;

    localparam logic FMT_ESCAPE = 1'b0;

    localparam logic [11:0] PITCH_RESET = 12'd1024;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
        logic [9:0] glyph_width;
        logic [9:0] glyph_height;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  pixel_a;
        logic [7:0]  pixel_b;
        logic [7:0]  pixel_c;
        logic [7:0]  pixel_d;
        logic [21:0] addr_a;
        logic [21:0] addr_b;
        logic [21:0] addr_c;
        logic [21:0] addr_d;
        logic [2:0]  valid_count;
        logic        last_pixel;
    } t_out_item;

    // Controller to datapath.
    typedef struct packed {
        logic accept;
        logic emit;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic run_active;
        logic slot_free;
        logic final_group;
    } t_dp_status;

endpackage

@@ rtl/glyph_run_length_decoder_core.sv @@
// Glyph run-length decoder: top level joining sequencer and datapath.
// A data byte is taken in the idle state; its groups are formed in the emit state
// and registered in the output register. A new transaction is taken only after
// the last one is through; a data byte's groups leave the 4-lane address chain
// one group per cycle while the output register is free, and stall with it.
// Reset: synchronous, active low; clears all counters, format to 1, pitch to 1024.
module glyph_run_length_decoder_core import grld_pkg::*; #(
    parameter int unsigned MAX_DIM = 1024,
    parameter int unsigned MAX_PITCH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [11:0] i_cfg_data,
    // compressed byte / start transactions
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    // pixel group transactions
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // The sequencer takes one transaction while idle, then issues one emit
    // per cycle whenever the output register is free, until the run is spent
    // or the glyph is complete.
    grld_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // The datapath decodes the byte on accept (escape, run or literal) and
    // forms up to four pitched pixel addresses per emit.
    grld_dpath #(
        .MAX_DIM   (MAX_DIM),
        .MAX_PITCH (MAX_PITCH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

@@ rtl/grld_ctrl.sv @@
// Sequencer of the glyph run-length decoder: accepts one transaction, then
// steps the datapath through the pixel groups of its run. Uses grld_pkg.
module grld_ctrl import grld_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd.accept = 1'b0;
        o_cmd.emit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // drop out when nothing is left; advance one group per free slot
                if (!i_status.run_active) begin
                    n_state = S_IDLE;
                end else if (i_status.slot_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.final_group) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

@@ rtl/grld_dpath.sv @@
// Datapath of the glyph run-length decoder: config registers, glyph state,
// four-lane pixel address chain and the output register. Uses grld_pkg.
module grld_dpath import grld_pkg::*; #(
    parameter int unsigned MAX_DIM = 1024,
    parameter int unsigned MAX_PITCH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [11:0] i_cfg_data,
    input  t_in_item    i_item,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_status,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output t_out_item   o_out_data
);

    logic        r_format;
    logic [11:0] r_pitch;
    logic [7:0]  r_prev;
    logic [19:0] r_done;
    logic [19:0] r_total;
    logic [9:0]  r_width;
    logic [9:0]  r_col;
    logic [21:0] r_base;
    logic        r_await;
    logic [7:0]  r_run_len;
    logic        r_out_valid;
    t_out_item   r_out;

    // Item decode
    logic [9:0]  w_sat;
    logic [9:0]  h_sat;
    logic [7:0]  dec_len;
    logic [7:0]  dec_val;
    logic        dec_await;

    // Group formation
    logic [9:0]  col_chain [GROUP+1];
    logic [21:0] base_chain [GROUP+1];
    logic [21:0] lane_addr [GROUP];
    logic [GROUP-1:0] lane_ok;
    logic [10:0] col_inc;
    logic [2:0]  cnt;
    logic [19:0] remain;
    logic [19:0] done_next;
    logic [11:0] pitch_sat;
    logic        grp_last;
    t_out_item   grp;

    always_comb begin
        w_sat = (32'(i_item.glyph_width) > MAX_DIM) ? 10'(MAX_DIM) : i_item.glyph_width;
        h_sat = (32'(i_item.glyph_height) > MAX_DIM) ? 10'(MAX_DIM) : i_item.glyph_height;
        pitch_sat = (32'(r_pitch) > MAX_PITCH) ? 12'(MAX_PITCH) : r_pitch;
    end

    always_comb begin
        dec_await = 1'b0;
        dec_len = 8'd1;
        dec_val = i_item.data_byte;
        priority if (r_await) begin
            dec_len = i_item.data_byte;
            dec_val = r_prev;
        end else if (r_format == FMT_ESCAPE) begin
            if (i_item.data_byte == ESCAPE_BYTE) begin
                dec_await = 1'b1;
                dec_len = 8'd0;
                dec_val = r_prev;
            end
        end else if (i_item.data_byte >= ESCAPE_BYTE) begin
            dec_len = i_item.data_byte - RUN_BIAS;
            dec_val = r_prev;
        end else begin
            // literal pixel
            dec_len = 8'd1;
            dec_val = i_item.data_byte;
        end
    end

    // Walk the column/row-base chain across the lanes.
    always_comb begin
        col_chain[0] = r_col;
        base_chain[0] = r_base;
        col_inc = '0;
        remain = r_total - r_done;
        cnt = '0;
        for (int k = 0; k < GROUP; k++) begin
            lane_addr[k] = base_chain[k] + 22'(col_chain[k]);
            col_inc = 11'(col_chain[k]) + 11'd1;
            if (col_inc >= 11'(r_width)) begin
                col_chain[k+1] = '0;
                base_chain[k+1] = base_chain[k] + 22'(pitch_sat);
            end else begin
                col_chain[k+1] = col_inc[9:0];
                base_chain[k+1] = base_chain[k];
            end
            lane_ok[k] = (r_run_len > 8'(k)) && (remain > 20'(k));
            cnt = cnt + 3'(lane_ok[k]);
        end
        done_next = r_done + 20'(cnt);
        grp_last = (done_next == r_total);

        grp.pixel_a = lane_ok[0] ? r_prev : 8'd0;
        grp.pixel_b = lane_ok[1] ? r_prev : 8'd0;
        grp.pixel_c = lane_ok[2] ? r_prev : 8'd0;
        grp.pixel_d = lane_ok[3] ? r_prev : 8'd0;
        grp.addr_a = lane_ok[0] ? lane_addr[0] : 22'd0;
        grp.addr_b = lane_ok[1] ? lane_addr[1] : 22'd0;
        grp.addr_c = lane_ok[2] ? lane_addr[2] : 22'd0;
        grp.addr_d = lane_ok[3] ? lane_addr[3] : 22'd0;
        grp.valid_count = cnt;
        grp.last_pixel = grp_last;
    end

    assign o_status.run_active = (r_run_len != 8'd0) && (r_done < r_total);
    assign o_status.slot_free = !r_out_valid || i_out_ready;
    assign o_status.final_group = (r_run_len == 8'(cnt)) || grp_last;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= 1'b1;
            r_pitch <= PITCH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FORMAT: r_format <= i_cfg_data[0];
                CFG_PITCH:  r_pitch <= i_cfg_data;
                default:    r_pitch <= r_pitch;
            endcase
        end
    end

    // Glyph state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_done <= '0;
            r_total <= '0;
            r_width <= '0;
            r_col <= '0;
            r_base <= '0;
            r_await <= 1'b0;
            r_run_len <= '0;
        end else if (i_cmd.accept) begin
            if (i_item.op == OP_START) begin
                r_width <= w_sat;
                r_total <= 20'(w_sat) * 20'(h_sat);
                r_done <= '0;
                r_col <= '0;
                r_base <= '0;
                r_prev <= '0;
                r_await <= 1'b0;
                r_run_len <= '0;
            end else if (r_done < r_total) begin
                r_await <= dec_await;
                r_prev <= dec_val;
                r_run_len <= dec_len;
            end else begin
                r_run_len <= '0;
            end
        end else if (i_cmd.emit) begin
            r_run_len <= r_run_len - 8'(cnt);
            r_done <= done_next;
            r_col <= col_chain[cnt];
            r_base <= base_chain[cnt];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= grp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

endmodule

@@ rtl/grld_checker.sv @@
// Port-level checks of the glyph run-length decoder core, bound to the top.
// Uses grld_pkg.
module grld_checker import grld_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.valid_count != 3'd0) && (o_out_data.valid_count <= 3'd4))
        else $error("group count out of range");

    a_unused_lane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.valid_count != 3'd4)
        |-> (o_out_data.pixel_d == 8'd0) && (o_out_data.addr_d == 22'd0))
        else $error("unused lane not cleared");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second transaction taken while busy");

endmodule

bind glyph_run_length_decoder_core grld_checker u_grld_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench for glyph_run_length_decoder_core: a short directed stream, then random glyphs
// in several register settings, with a class that predicts and checks every pixel group.
// Depends on grld_pkg and the decoder RTL.
module tb_top;
    import grld_pkg::*;

    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned ITEM_TARGET = 260;
    localparam int unsigned PHASE_COUNT = 4;

    // Tracks the decoder state and queues the pixel groups each transaction must produce.
    class pixel_group_checker;
        bit          fmt;
        logic [11:0] pitch;
        logic [7:0]  prev_pixel;
        int unsigned done_pixels;
        int unsigned total_pixels;
        int unsigned width;
        int unsigned col;
        logic [21:0] row_base;
        bit          await_len;
        int unsigned errors;
        logic [7:0]  lane_pix[GROUP];
        logic [21:0] lane_addr[GROUP];
        t_out_item   pending_groups[$];

        function new();
            fmt = 1'b1;
            pitch = PITCH_RESET;
            prev_pixel = '0;
            done_pixels = 0;
            total_pixels = 0;
            width = 0;
            col = 0;
            row_base = '0;
            await_len = 1'b0;
            errors = 0;
        endfunction

        function void set_register(logic idx, logic [11:0] val);
            if (idx == CFG_FORMAT) begin
                fmt = val[0];
            end else begin
                pitch = val;
            end
        endfunction

        function bit glyph_complete();
            return done_pixels >= total_pixels;
        endfunction

        function void push_group(int unsigned fill, bit last);
            t_out_item g;
            g = '0;
            if (fill > 0) begin
                g.pixel_a = lane_pix[0];
                g.addr_a = lane_addr[0];
            end
            if (fill > 1) begin
                g.pixel_b = lane_pix[1];
                g.addr_b = lane_addr[1];
            end
            if (fill > 2) begin
                g.pixel_c = lane_pix[2];
                g.addr_c = lane_addr[2];
            end
            if (fill > 3) begin
                g.pixel_d = lane_pix[3];
                g.addr_d = lane_addr[3];
            end
            g.valid_count = 3'(fill);
            g.last_pixel = last;
            pending_groups.push_back(g);
        endfunction

        // Returns 1 when the transaction does work, 0 when the decoder ignores it.
        function bit absorb_item(t_in_item it);
            int unsigned run_len;
            int unsigned fill;
            logic [7:0]  value;
            bit          last;
            if (it.op == OP_START) begin
                width = it.glyph_width;
                total_pixels = int'(it.glyph_width) * int'(it.glyph_height);
                done_pixels = 0;
                col = 0;
                row_base = '0;
                prev_pixel = '0;
                await_len = 1'b0;
                return 1'b1;
            end
            // drop bytes once the glyph is complete
            if (glyph_complete())
                return 1'b0;
            if (await_len) begin
                // a pending escape wins over the current format
                await_len = 1'b0;
                run_len = it.data_byte;
                value = prev_pixel;
            end else if (fmt == FMT_ESCAPE) begin
                if (it.data_byte == ESCAPE_BYTE) begin
                    await_len = 1'b1;
                    return 1'b1;
                end
                run_len = 1;
                value = it.data_byte;
            end else if (it.data_byte >= ESCAPE_BYTE) begin
                run_len = it.data_byte - RUN_BIAS;
                value = prev_pixel;
            end else begin
                run_len = 1;
                value = it.data_byte;
            end
            prev_pixel = value;
            fill = 0;
            last = 1'b0;
            for (int unsigned i = 0; i < run_len && done_pixels < total_pixels; i++) begin
                lane_pix[fill] = value;
                lane_addr[fill] = row_base + 22'(col);
                fill++;
                done_pixels++;
                if (done_pixels == total_pixels)
                    last = 1'b1;
                col++;
                if (col >= width) begin
                    col = 0;
                    row_base = row_base + 22'(pitch);
                end
                if (fill == GROUP) begin
                    push_group(fill, last);
                    fill = 0;
                    last = 1'b0;
                end
            end
            if (fill != 0)
                push_group(fill, last);
            return 1'b1;
        endfunction

        function void check_field(string name, int unsigned want_v, int unsigned got_v);
            if (want_v != got_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
            end
        endfunction

        function void compare_group(t_out_item got);
            t_out_item want;
            if (pending_groups.size() == 0) begin
                errors++;
                $display("%0t: pixel group with none expected, expected nothing, got %h",
                         $time, got);
                return;
            end
            want = pending_groups.pop_front();
            check_field("pixel_a", want.pixel_a, got.pixel_a);
            check_field("pixel_b", want.pixel_b, got.pixel_b);
            check_field("pixel_c", want.pixel_c, got.pixel_c);
            check_field("pixel_d", want.pixel_d, got.pixel_d);
            check_field("addr_a", want.addr_a, got.addr_a);
            check_field("addr_b", want.addr_b, got.addr_b);
            check_field("addr_c", want.addr_c, got.addr_c);
            check_field("addr_d", want.addr_d, got.addr_d);
            check_field("valid_count", want.valid_count, got.valid_count);
            check_field("last_pixel", want.last_pixel, got.last_pixel);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [11:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    t_in_item    in_data;
    logic        out_valid;
    logic        out_ready;
    t_out_item   out_data;

    pixel_group_checker model = new();
    bit          send_eager;
    bit          recv_eager;
    bit          hold_off_req;
    int unsigned useful_items;

    glyph_run_length_decoder_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int unsigned draw_gap(bit eager);
        return eager ? 0 : $urandom_range(0, 17);
    endfunction

    // Offer one transaction after a random gap and hold it until accepted.
    task automatic send_item(t_in_item it);
        int unsigned gap;
        if ($urandom_range(0, 24) == 0)
            send_eager = !send_eager;
        gap = draw_gap(send_eager);
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (!in_ready);
        if (model.absorb_item(it))
            useful_items++;
    endtask

    task automatic send_start(int unsigned w, int unsigned h);
        t_in_item it;
        it = '0;
        it.op = OP_START;
        it.glyph_width = 10'(w);
        it.glyph_height = 10'(h);
        send_item(it);
    endtask

    task automatic send_byte(logic [7:0] b);
        t_in_item it;
        it = '0;
        it.op = OP_DATA;
        it.data_byte = b;
        send_item(it);
    endtask

    task automatic stop_sending();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Wait until every predicted group has left, then let in-flight work settle.
    task automatic wait_idle();
        while (model.pending_groups.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic idx, logic [11:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        model.set_register(idx, val);
    endtask

    // Mostly well-formed glyphs with random content; some starts cut glyphs short,
    // some bytes are pure noise, and a few land after the glyph is complete.
    function automatic t_in_item make_item();
        t_in_item    it;
        int unsigned pick;
        it.op = OP_DATA;
        it.data_byte = 8'($urandom);
        it.glyph_width = 10'($urandom);
        it.glyph_height = 10'($urandom);
        pick = $urandom_range(0, 99);
        if ((model.glyph_complete() && pick >= 15) || pick < 4) begin
            it.op = OP_START;
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                if ($urandom_range(0, 1))
                    it.glyph_width = '0;
                else
                    it.glyph_height = '0;
            end else if (pick > 1) begin
                it.glyph_width = 10'($urandom_range(1, 24));
                it.glyph_height = 10'($urandom_range(1, 16));
            end
        end else if (pick < 10) begin
            // keep the random byte as drawn
        end else if (model.await_len) begin
            if ($urandom_range(0, 7) != 0)
                it.data_byte = 8'($urandom_range(0, 16));
        end else if (model.fmt == FMT_ESCAPE) begin
            if (pick < 25)
                it.data_byte = ESCAPE_BYTE;
        end else if (pick < 60) begin
            it.data_byte = 8'($urandom_range(0, 64));
        end else if ($urandom_range(0, 3) == 0) begin
            it.data_byte = 8'($urandom_range(65, 255));
        end else begin
            it.data_byte = 8'($urandom_range(65, 80));
        end
        return it;
    endfunction

    // Result side: random stalls per transaction, plus one long hold-off on request.
    initial begin : result_side
        int unsigned gap;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 24) == 0)
                recv_eager = !recv_eager;
            gap = draw_gap(recv_eager);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                gap = HOLD_OFF_CYCLES;
            end
            if (gap > 0) begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            model.compare_group(out_data);
        end
    end

    initial begin : stimulus
        bit          fmt_sel;
        logic [11:0] pitch_sel;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_FORMAT;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        send_eager = 1'b0;
        recv_eager = 1'b0;
        hold_off_req = 1'b0;
        useful_items = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: run-in-byte format, pitch 1024.
        send_byte(8'h10);       // no glyph yet, drop
        send_start(3, 2);
        send_byte(8'h45);       // run before any pixel repeats 0, wraps a row
        send_byte(8'h00);       // final pixel
        send_byte(8'h20);       // glyph complete, ignore
        send_start(0, 5);       // empty glyph
        send_byte(8'h30);
        send_start(1023, 1023);
        send_byte(8'hFF);       // longest run in this format
        send_byte(8'h40);       // largest literal
        send_byte(8'h41);       // shortest run
        send_byte(8'h3F);

        stop_sending();
        wait_idle();
        write_register(CFG_FORMAT, {11'b0, FMT_ESCAPE});
        write_register(CFG_PITCH, 12'd1);   // pitch below width, addresses overlap
        send_start(5, 3);
        send_byte(8'hFF);       // plain literal in escape format
        send_byte(ESCAPE_BYTE);
        send_byte(8'h00);       // zero-length run, no group
        send_byte(ESCAPE_BYTE);
        send_byte(8'hFF);       // run past the glyph end, drop the excess
        send_start(2, 1023);
        send_byte(ESCAPE_BYTE); // escape left pending, cleared by next start
        send_start(4, 4);
        send_byte(8'h55);
        send_byte(ESCAPE_BYTE);

        // Switch format with the escape still pending; the next byte stays a length.
        stop_sending();
        wait_idle();
        write_register(CFG_FORMAT, 12'd1);
        write_register(CFG_PITCH, 12'd4095);
        send_byte(8'h09);
        send_byte(8'h80);

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            stop_sending();
            wait_idle();
            case (phase)
                0: begin
                    fmt_sel = 1'b1;
                    pitch_sel = 12'd4095;
                end
                1: begin
                    fmt_sel = FMT_ESCAPE;
                    pitch_sel = 12'd1;
                end
                default: begin
                    fmt_sel = 1'($urandom_range(0, 1));
                    pitch_sel = 12'($urandom_range(1, 4095));
                end
            endcase
            write_register(CFG_FORMAT, {11'b0, fmt_sel});
            write_register(CFG_PITCH, pitch_sel);
            // Stall the result side for a long stretch while transactions keep coming.
            if (phase == 2)
                hold_off_req = 1'b1;
            while (useful_items < (phase + 1) * ITEM_TARGET / PHASE_COUNT)
                send_item(make_item());
        end

        stop_sending();
        wait_idle();
        if (model.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin : watchdog
        #12_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
